// File: design/spc_pkg.sv
package spc_pkg;

    // Field widths of the words on both channels.
    localparam int AXIS_W = 9;
    localparam int MAG_W  = 8;
    localparam int ANG_W  = 9;

    // Internal widths.  The magnitude of an axis reaches 256 when an input is -256.
    localparam int ABS_W  = AXIS_W;
    localparam int SQ_W   = 2 * ABS_W - 1;
    localparam int SUM_W  = SQ_W + 1;
    localparam int RAD_W  = 31;
    localparam int DEG_W  = 6;
    localparam int TRIG_W = 52;
    localparam int PROD_W = ABS_W + TRIG_W;

    localparam int AXIS_FULL_SCALE_DEF = 255;
    localparam int PCT_SCALE           = 10000;

    // Highest whole degree held in the sine and cosine tables.
    localparam int ATAN_TOP     = 44;
    localparam int TAB_SIZE     = 2 ** DEG_W;
    localparam int SERIES_TERMS = 24;

    localparam logic [ANG_W-1:0] ANGLE_EIGHTH  = ANG_W'(45);
    localparam logic [ANG_W-1:0] ANGLE_QUARTER = ANG_W'(90);
    localparam logic [ANG_W-1:0] ANGLE_HALF    = ANG_W'(180);
    localparam logic [ANG_W-1:0] ANGLE_FULL    = ANG_W'(360);

    // Pipeline layout: stage of the axis prep, stage of the percent scaling,
    // first stage of the degree search and of the root search, and the angle fixup.
    localparam int PREP_STAGE  = 0;
    localparam int SCALE_STAGE = 1;
    localparam int ATAN_FIRST  = 1;
    localparam int FIX_STAGE   = ATAN_FIRST + DEG_W;
    localparam int ROOT_FIRST  = 2;
    localparam int NUM_STAGES  = ROOT_FIRST + MAG_W;

    localparam logic [63:0] PI_Q62  = 64'hC90FDAA22168C235;
    localparam logic [63:0] ONE_Q62 = 64'h4000000000000000;

    typedef struct packed {
        logic swap;
        logic eq;
        logic px_neg;
        logic py_neg;
        logic center;
    } t_dir;

    typedef struct packed {
        logic [SUM_W-1:0] sq_sum;
        logic [RAD_W-1:0] rem;
        logic [RAD_W-1:0] tq;
        logic [MAG_W-1:0] mag;
        logic [ABS_W-1:0] lo;
        logic [ABS_W-1:0] hi;
        logic [DEG_W-1:0] d;
        t_dir             dir;
        logic [ANG_W-1:0] angle;
    } t_word;

    typedef logic [TRIG_W-1:0] t_trig_tab [TAB_SIZE];

    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // Sine or cosine of whole degrees in Q52, summed as a Taylor series in Q62.
    function automatic t_trig_tab build_trig(input logic want_cos);
        t_trig_tab   tab;
        logic [63:0] one_deg;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] s;
        logic [63:0] c;
        logic [63:0] ts;
        logic [63:0] tc;
        one_deg = PI_Q62 / 64'd180;
        for (int i = 0; i < TAB_SIZE; i++) begin
            tab[i] = '0;
        end
        for (int d = 1; d <= ATAN_TOP; d++) begin
            x  = one_deg * 64'(d);
            x2 = mul_q62(x, x);
            s  = x;
            c  = ONE_Q62;
            ts = x;
            tc = ONE_Q62;
            for (int k = 1; k < SERIES_TERMS; k++) begin
                ts = mul_q62(ts, x2) / 64'((2 * k) * (2 * k + 1));
                tc = mul_q62(tc, x2) / 64'((2 * k - 1) * (2 * k));
                if ((k & 1) != 0) begin
                    s = s - ts;
                    c = c - tc;
                end else begin
                    s = s + ts;
                    c = c + tc;
                end
            end
            if (want_cos) begin
                tab[d] = TRIG_W'((c + 64'd512) >> 10);
            end else begin
                tab[d] = TRIG_W'((s + 64'd512) >> 10);
            end
        end
        return tab;
    endfunction

    localparam t_trig_tab SIN_TAB = build_trig(1'b0);
    localparam t_trig_tab COS_TAB = build_trig(1'b1);

endpackage

// File: design/spc_axis_if.sv
interface spc_axis_if;
    logic                              valid;
    logic                              ready;
    logic signed [spc_pkg::AXIS_W-1:0] axis_x;
    logic signed [spc_pkg::AXIS_W-1:0] axis_y;

    modport source (output valid, output axis_x, output axis_y, input ready);
    modport sink (input valid, input axis_x, input axis_y, output ready);
endinterface

// File: design/spc_polar_if.sv
interface spc_polar_if;
    logic                       valid;
    logic                       ready;
    logic [spc_pkg::MAG_W-1:0] magnitude_pct;
    logic [spc_pkg::ANG_W-1:0] angle_deg;

    modport source (output valid, output magnitude_pct, output angle_deg, input ready);
    modport sink (input valid, input magnitude_pct, input angle_deg, output ready);
endinterface

// File: design/spc_prep.sv
module spc_prep (
    input  logic signed [spc_pkg::AXIS_W-1:0] i_axis_x,
    input  logic signed [spc_pkg::AXIS_W-1:0] i_axis_y,
    output spc_pkg::t_word                    o_word
);

    logic [spc_pkg::ABS_W-1:0] w_abs_x;
    logic [spc_pkg::ABS_W-1:0] w_abs_y;
    logic [spc_pkg::SQ_W-1:0]  w_sq_x;
    logic [spc_pkg::SQ_W-1:0]  w_sq_y;
    logic                      w_swap;

    assign w_abs_x = i_axis_x[spc_pkg::AXIS_W-1] ? $unsigned(-i_axis_x) : $unsigned(i_axis_x);
    assign w_abs_y = i_axis_y[spc_pkg::AXIS_W-1] ? $unsigned(-i_axis_y) : $unsigned(i_axis_y);
    assign w_sq_x  = spc_pkg::SQ_W'(w_abs_x) * spc_pkg::SQ_W'(w_abs_x);
    assign w_sq_y  = spc_pkg::SQ_W'(w_abs_y) * spc_pkg::SQ_W'(w_abs_y);

    // The angle is taken on the rotated pair (-y, -x), so |x| is the opposite side.
    assign w_swap = w_abs_x > w_abs_y;

    always_comb begin
        o_word            = '0;
        o_word.sq_sum     = spc_pkg::SUM_W'(w_sq_x) + spc_pkg::SUM_W'(w_sq_y);
        o_word.lo         = w_swap ? w_abs_y : w_abs_x;
        o_word.hi         = w_swap ? w_abs_x : w_abs_y;
        o_word.dir.swap   = w_swap;
        o_word.dir.eq     = w_abs_x == w_abs_y;
        o_word.dir.px_neg = !i_axis_y[spc_pkg::AXIS_W-1] && (i_axis_y != '0);
        o_word.dir.py_neg = !i_axis_x[spc_pkg::AXIS_W-1] && (i_axis_x != '0);
        o_word.dir.center = (i_axis_x == '0) && (i_axis_y == '0);
    end

endmodule

// File: design/spc_atan_step.sv
module spc_atan_step #(
    parameter int BIT_POS = 0
) (
    input  spc_pkg::t_word i_word,
    output spc_pkg::t_word o_word
);

    localparam logic [spc_pkg::DEG_W-1:0] StepMask = spc_pkg::DEG_W'(1 << BIT_POS);

    logic [spc_pkg::DEG_W-1:0]  w_cand;
    logic [spc_pkg::PROD_W-1:0] w_lhs;
    logic [spc_pkg::PROD_W-1:0] w_rhs;
    logic                       w_take;

    // A degree k is reached when lo * cos(k) >= hi * sin(k).
    assign w_cand = i_word.d | StepMask;
    assign w_lhs  = spc_pkg::PROD_W'(i_word.lo) * spc_pkg::PROD_W'(spc_pkg::COS_TAB[w_cand]);
    assign w_rhs  = spc_pkg::PROD_W'(i_word.hi) * spc_pkg::PROD_W'(spc_pkg::SIN_TAB[w_cand]);
    assign w_take = (w_cand <= spc_pkg::DEG_W'(spc_pkg::ATAN_TOP)) && (w_lhs >= w_rhs);

    always_comb begin
        o_word = i_word;
        if (w_take) begin
            o_word.d = w_cand;
        end
    end

endmodule

// File: design/spc_root_step.sv
module spc_root_step #(
    parameter int AXIS_FULL_SCALE = spc_pkg::AXIS_FULL_SCALE_DEF,
    parameter int BIT_POS         = 0
) (
    input  spc_pkg::t_word i_word,
    output spc_pkg::t_word o_word
);

    localparam int FsqW  = 2 * $clog2(AXIS_FULL_SCALE + 1);
    localparam int TqTop = spc_pkg::RAD_W + spc_pkg::MAG_W;
    localparam int SqTop = FsqW + 2 * spc_pkg::MAG_W - 2;
    localparam int TestW = ((TqTop > SqTop) ? TqTop : SqTop) + 1;
    localparam logic [FsqW-1:0] FsSq = FsqW'(AXIS_FULL_SCALE * AXIS_FULL_SCALE);

    logic [TestW-1:0] w_test;
    logic [TestW-1:0] w_tq_add;
    logic             w_fit;

    // rem holds N - S*m*m and tq holds S*m, with S the full scale squared.
    // Setting bit j of m costs S*(2^(j+1)*m + 2^(2j)).
    assign w_test   = (TestW'(i_word.tq) << (BIT_POS + 1)) + (TestW'(FsSq) << (2 * BIT_POS));
    assign w_tq_add = TestW'(FsSq) << BIT_POS;
    assign w_fit    = w_test <= TestW'(i_word.rem);

    always_comb begin
        o_word = i_word;
        if (w_fit) begin
            o_word.rem          = i_word.rem - spc_pkg::RAD_W'(w_test);
            o_word.tq           = i_word.tq + spc_pkg::RAD_W'(w_tq_add);
            o_word.mag[BIT_POS] = 1'b1;
        end
    end

endmodule

// File: design/spc_angle_fix.sv
module spc_angle_fix (
    input  spc_pkg::t_word i_word,
    output spc_pkg::t_word o_word
);

    logic [spc_pkg::ANG_W-1:0] w_sf;
    logic [spc_pkg::ANG_W-1:0] w_step;
    logic [spc_pkg::ANG_W-1:0] w_pf;
    logic [spc_pkg::ANG_W-1:0] w_pc;
    logic [spc_pkg::ANG_W-1:0] w_fl;
    logic                      w_exact;

    // w_sf is the floor of the smaller octant angle; w_step is one unless it is exact.
    assign w_sf    = i_word.dir.eq ? spc_pkg::ANGLE_EIGHTH : spc_pkg::ANG_W'(i_word.d);
    assign w_exact = i_word.dir.eq || ((i_word.d == '0) && (i_word.lo == '0));
    assign w_step  = w_exact ? '0 : spc_pkg::ANG_W'(1);

    always_comb begin
        if (i_word.dir.swap) begin
            w_pf = spc_pkg::ANGLE_QUARTER - w_sf - w_step;
            w_pc = spc_pkg::ANGLE_QUARTER - w_sf;
        end else begin
            w_pf = w_sf;
            w_pc = w_sf + w_step;
        end
        w_fl = i_word.dir.px_neg ? (spc_pkg::ANGLE_HALF - w_pc) : w_pf;

        o_word = i_word;
        if (i_word.dir.center) begin
            o_word.angle = spc_pkg::ANGLE_HALF;
        end else if (i_word.dir.py_neg && (w_fl != '0)) begin
            o_word.angle = spc_pkg::ANGLE_FULL - w_fl;
        end else begin
            o_word.angle = w_fl;
        end
    end

endmodule

// File: design/stick_polar_convert_core.sv
// Channel   Direction  Word contents                         Handshake
// i_axis    in         axis_x, axis_y (signed, 9 bits each)  valid / ready
// o_polar   out        magnitude_pct (8), angle_deg (9)      valid / ready
//
// One word is taken in every cycle unless a stall at o_polar has filled the pipeline.
// The pipeline holds one stage of axis prep, one stage of percent scaling and the
// eight-step square root search for the magnitude.
// Reset clears only the valid bits of the ten pipeline stages; data registers have no reset.
// A stall at o_polar fills empty stages first, so words keep entering until the
// pipeline is full; no word is dropped or repeated.
module stick_polar_convert_core #(
    parameter int AXIS_FULL_SCALE = spc_pkg::AXIS_FULL_SCALE_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    spc_axis_if.sink           i_axis,
    spc_polar_if.source        o_polar
);

    localparam int LastStage = spc_pkg::NUM_STAGES - 1;
    localparam int AtanEnd   = spc_pkg::FIX_STAGE - 1;

    // Every stage carries the whole word; each stage fills in the fields it owns.
    spc_pkg::t_word                    r_word [spc_pkg::NUM_STAGES];
    spc_pkg::t_word                    w_next [spc_pkg::NUM_STAGES];
    logic [spc_pkg::NUM_STAGES-1:0]    r_valid;
    logic [spc_pkg::NUM_STAGES-1:0]    n_valid;
    logic [spc_pkg::NUM_STAGES:0]      w_ready;

    // A stage may load when it is empty or when its word moves on in the same cycle.
    assign w_ready[spc_pkg::NUM_STAGES] = o_polar.ready;

    for (genvar s = 0; s < spc_pkg::NUM_STAGES; s++) begin : g_stage
        assign w_ready[s] = !r_valid[s] || w_ready[s+1];

        if (s == spc_pkg::PREP_STAGE) begin : g_prep
            assign n_valid[s] = i_axis.valid;
            spc_prep u_prep (
                .i_axis_x (i_axis.axis_x),
                .i_axis_y (i_axis.axis_y),
                .o_word   (w_next[s])
            );
        end else begin : g_work
            spc_pkg::t_word w_a;
            spc_pkg::t_word w_b;
            spc_pkg::t_word w_c;
            spc_pkg::t_word w_d;

            assign n_valid[s] = r_valid[s-1];

            // Percent scaling: the root search looks for m with S*m*m <= 10000*(x*x+y*y).
            if (s == spc_pkg::SCALE_STAGE) begin : g_scale
                always_comb begin
                    w_a     = r_word[s-1];
                    w_a.rem = spc_pkg::RAD_W'(32'(r_word[s-1].sq_sum) * 32'(spc_pkg::PCT_SCALE));
                    w_a.tq  = '0;
                    w_a.mag = '0;
                end
            end else begin : g_scale_pass
                assign w_a = r_word[s-1];
            end

            // Binary search for the whole degree, most significant bit first.
            if (s >= spc_pkg::ATAN_FIRST && s < spc_pkg::ATAN_FIRST + spc_pkg::DEG_W)
            begin : g_atan
                spc_atan_step #(
                    .BIT_POS (spc_pkg::DEG_W - 1 - (s - spc_pkg::ATAN_FIRST))
                ) u_atan (
                    .i_word (w_a),
                    .o_word (w_b)
                );
            end else begin : g_atan_pass
                assign w_b = w_a;
            end

            // Quadrant and octant unfolding of the degree.
            if (s == spc_pkg::FIX_STAGE) begin : g_fix
                spc_angle_fix u_fix (
                    .i_word (w_b),
                    .o_word (w_c)
                );
            end else begin : g_fix_pass
                assign w_c = w_b;
            end

            // Square root search for the magnitude, one result bit per stage.
            if (s >= spc_pkg::ROOT_FIRST) begin : g_root
                spc_root_step #(
                    .AXIS_FULL_SCALE (AXIS_FULL_SCALE),
                    .BIT_POS         (spc_pkg::MAG_W - 1 - (s - spc_pkg::ROOT_FIRST))
                ) u_root (
                    .i_word (w_c),
                    .o_word (w_d)
                );
            end else begin : g_root_pass
                assign w_d = w_c;
            end

            assign w_next[s] = w_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            for (int s = 0; s < spc_pkg::NUM_STAGES; s++) begin
                if (w_ready[s]) begin
                    r_valid[s] <= n_valid[s];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < spc_pkg::NUM_STAGES; s++) begin
            if (w_ready[s]) begin
                r_word[s] <= w_next[s];
            end
        end
    end

    assign i_axis.ready          = w_ready[0];
    assign o_polar.valid         = r_valid[LastStage];
    assign o_polar.magnitude_pct = r_word[LastStage].mag;
    assign o_polar.angle_deg     = r_word[LastStage].angle;

    // A word in the first stage stays put while the second stage cannot take it.
    a_prep_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[0] && !w_ready[1] |=> r_valid[0] && $stable(r_word[0]))
        else $error("prep stage word changed during a stall");

    // The degree search never leaves the range of the tables.
    a_deg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[AtanEnd] |-> r_word[AtanEnd].d <= spc_pkg::DEG_W'(spc_pkg::ATAN_TOP))
        else $error("degree search went past the table");

    // A centered stick points at half a turn.
    a_center: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[spc_pkg::FIX_STAGE] && r_word[spc_pkg::FIX_STAGE].dir.center
        |-> r_word[spc_pkg::FIX_STAGE].angle == spc_pkg::ANGLE_HALF)
        else $error("centered stick gave a wrong angle");

    // Whatever the path, the angle stays below a full turn.
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_polar.valid |-> o_polar.angle_deg < spc_pkg::ANGLE_FULL)
        else $error("angle out of range");

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;

    // Expected contents of one word on the polar channel.
    typedef struct {
        logic [spc_pkg::MAG_W-1:0] mag;
        logic [spc_pkg::ANG_W-1:0] ang;
    } t_polar;

    // Holds the polar words still owed by the block, in order of acceptance,
    // and checks each word that leaves the block against the oldest of them.
    class t_polar_ledger;
        t_polar      owed_q[$];
        real         sin_deg[spc_pkg::ATAN_TOP+1];
        real         cos_deg[spc_pkg::ATAN_TOP+1];
        int unsigned mismatches;

        function new();
            real rad;
            mismatches = 0;
            for (int k = 0; k <= spc_pkg::ATAN_TOP; k++) begin
                rad        = real'(k) * 3.14159265358979323846 / 180.0;
                sin_deg[k] = $sin(rad);
                cos_deg[k] = $cos(rad);
            end
        endfunction

        // Largest r with r*r <= n.
        function longint unsigned root_floor(longint unsigned n);
            longint unsigned r;
            longint unsigned t;
            r = 0;
            for (int i = 20; i >= 0; i--) begin
                t = r | (64'd1 << i);
                if (t * t <= n) r = t;
            end
            return r;
        endfunction

        // Whole degrees of atan(lo/hi), rounded down, for lo <= hi and hi > 0.
        // The flag tells whether the angle is a whole degree itself.
        function int unsigned floor_degrees(int unsigned lo, int unsigned hi,
                                            output bit exact);
            int unsigned deg;
            deg   = 0;
            exact = 1'b0;
            if (lo == hi) begin
                exact = 1'b1;
                return spc_pkg::ANGLE_EIGHTH;
            end
            for (int k = 1; k <= spc_pkg::ATAN_TOP; k++) begin
                if (real'(lo) * cos_deg[k] >= real'(hi) * sin_deg[k]) deg = k;
                else break;
            end
            exact = (deg == 0 && lo == 0);
            return deg;
        endfunction

        function t_polar polar_of(logic signed [spc_pkg::AXIS_W-1:0] x,
                                  logic signed [spc_pkg::AXIS_W-1:0] y);
            int              xs;
            int              ys;
            int              px;
            int              py;
            int unsigned     lo;
            int unsigned     hi;
            int unsigned     pf;
            int unsigned     pc;
            int unsigned     f2;
            int unsigned     fl;
            int unsigned     ang;
            longint unsigned mag;
            bit              ex;
            t_polar          r;
            xs  = x;
            ys  = y;
            px  = -ys;
            py  = -xs;
            mag = root_floor(longint'(xs * xs + ys * ys) * spc_pkg::PCT_SCALE)
                  / spc_pkg::AXIS_FULL_SCALE_DEF;
            if (mag > 255) mag = 255;
            if (px == 0 && py == 0) begin
                ang = spc_pkg::ANGLE_HALF;
            end else begin
                lo = (py < 0) ? -py : py;
                hi = (px < 0) ? -px : px;
                if (lo <= hi) begin
                    pf = floor_degrees(lo, hi, ex);
                    pc = pf + (ex ? 0 : 1);
                end else begin
                    f2 = floor_degrees(hi, lo, ex);
                    pf = spc_pkg::ANGLE_QUARTER - (f2 + (ex ? 0 : 1));
                    pc = spc_pkg::ANGLE_QUARTER - f2;
                end
                fl = (px >= 0) ? pf : spc_pkg::ANGLE_HALF - pc;
                if (py < 0) ang = (fl == 0) ? 0 : spc_pkg::ANGLE_FULL - fl;
                else ang = fl;
            end
            r.mag = spc_pkg::MAG_W'(mag);
            r.ang = spc_pkg::ANG_W'(ang);
            return r;
        endfunction

        function void note_sample(logic signed [spc_pkg::AXIS_W-1:0] x,
                                  logic signed [spc_pkg::AXIS_W-1:0] y);
            owed_q.push_back(polar_of(x, y));
        endfunction

        function void check_polar(logic [spc_pkg::MAG_W-1:0] mag,
                                  logic [spc_pkg::ANG_W-1:0] ang);
            t_polar want;
            if (owed_q.size() == 0) begin
                $error("unexpected polar word: magnitude_pct %0d angle_deg %0d", mag, ang);
                mismatches++;
                return;
            end
            want = owed_q.pop_front();
            if (mag !== want.mag) begin
                $error("magnitude_pct: expected %0d, got %0d", want.mag, mag);
                mismatches++;
            end
            if (ang !== want.ang) begin
                $error("angle_deg: expected %0d, got %0d", want.ang, ang);
                mismatches++;
            end
        endfunction

        function int unsigned outstanding();
            return owed_q.size();
        endfunction
    endclass

    localparam int RANDOM_WORDS = 700;
    localparam int CORNER_N     = 24;
    // After the final drain, a quiet stretch gives the block time to show any
    // stray word.
    localparam int TAIL_CYCLES  = 20;
    localparam int HOLD_CYCLES  = 70;

    // Directed samples: the centered stick, both signs on each axis alone, the
    // diagonals, the four full-scale corners, the small angles just either side
    // of straight up and straight down, and the out-of-range value -256.
    localparam int CORNER_X[CORNER_N] = '{
        0, 0, 0, 0, 0, 255, -255, 1, -1, 255, -255, 255,
        -255, 1, -1, 1, -1, -256, -256, 0, -256, 255, 3, -120
    };
    localparam int CORNER_Y[CORNER_N] = '{
        0, -1, 1, -255, 255, 0, 0, 1, -1, -255, 255, 255,
        -255, -255, -255, 255, 255, -256, 0, -256, 255, -256, -4, 209
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    spc_axis_if  axis_ch();
    spc_polar_if polar_ch();

    stick_polar_convert_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_axis  (axis_ch),
        .o_polar (polar_ch)
    );

    t_polar_ledger ledger = new();

    // Set by the stimulus to ask the receiver for one long hold-off.
    bit hold_request = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Both channels are observed at the rising edge, where every signal the
    // testbench drives has been stable since the falling edge before it.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (axis_ch.valid && axis_ch.ready) begin
                ledger.note_sample(axis_ch.axis_x, axis_ch.axis_y);
            end
            if (polar_ch.valid && polar_ch.ready) begin
                ledger.check_polar(polar_ch.magnitude_pct, polar_ch.angle_deg);
            end
        end
    end

    // Offers one word and returns once the block has taken it. Valid stays
    // high afterwards, so back-to-back calls form a burst without a gap.
    task automatic offer_word(input logic signed [spc_pkg::AXIS_W-1:0] x,
                              input logic signed [spc_pkg::AXIS_W-1:0] y);
        @(negedge i_clk);
        axis_ch.valid  <= 1'b1;
        axis_ch.axis_x <= x;
        axis_ch.axis_y <= y;
        do @(posedge i_clk); while (!axis_ch.ready);
    endtask

    // Drops valid for the given number of cycles, with junk on the data lines.
    task automatic go_quiet(input int unsigned cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            axis_ch.valid  <= 1'b0;
            axis_ch.axis_x <= spc_pkg::AXIS_W'($urandom);
            axis_ch.axis_y <= spc_pkg::AXIS_W'($urandom);
        end
    endtask

    // Holds off the sender until every polar word owed has come out.
    task automatic wait_drained();
        go_quiet(1);
        while (ledger.outstanding() != 0) @(posedge i_clk);
    endtask

    // Mostly uniform over all 512 codes, so every bit takes both values, with
    // extra weight on the full-scale values and on tiny deflections where the
    // angle is coarse and the axis signs matter most.
    function automatic logic signed [spc_pkg::AXIS_W-1:0] random_axis();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0: return spc_pkg::AXIS_W'(-256);
                    1: return -9'sd255;
                    2: return 9'sd255;
                    3: return 9'sd0;
                    default: return 9'sd1;
                endcase
            end
            1: return spc_pkg::AXIS_W'($urandom_range(0, 6) - 3);
            default: return spc_pkg::AXIS_W'($urandom_range(0, 511));
        endcase
    endfunction

    // Receiver: ready follows stretches of its own. A stretch is always
    // ready, coin-flip ready, a regular duty pattern, or a short hold. The
    // long hold asked for by the stimulus is counted out here.
    initial begin
        int unsigned stretch;
        int unsigned period;
        int unsigned mode;
        polar_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                repeat (HOLD_CYCLES) begin
                    @(negedge i_clk);
                    polar_ch.ready <= 1'b0;
                end
            end else begin
                mode    = $urandom_range(0, 7);
                stretch = $urandom_range(5, 40);
                period  = $urandom_range(2, 5);
                for (int n = 0; n < stretch; n++) begin
                    @(negedge i_clk);
                    case (mode)
                        0, 1, 2: polar_ch.ready <= 1'b1;
                        3, 4:    polar_ch.ready <= 1'($urandom_range(0, 1));
                        5, 6:    polar_ch.ready <= (n % period) != 0;
                        default: polar_ch.ready <= (n >= stretch / 2) ? 1'b1 : 1'b0;
                    endcase
                end
            end
        end
    end

    // Stimulus: directed words, then bursts of random words with random gaps.
    // Early in the random part the receiver is asked for a long hold while a
    // long burst is offered, which fills the pipeline and must stall the
    // input; halfway through, the sender waits for the block to drain.
    initial begin
        int  sent;
        int  burst;
        bit  hold_done;
        bit  pause_done;
        axis_ch.valid  = 1'b0;
        axis_ch.axis_x = '0;
        axis_ch.axis_y = '0;
        sent       = 0;
        hold_done  = 1'b0;
        pause_done = 1'b0;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < CORNER_N; i++) begin
            offer_word(spc_pkg::AXIS_W'(CORNER_X[i]), spc_pkg::AXIS_W'(CORNER_Y[i]));
            if ($urandom_range(0, 2) == 0) go_quiet($urandom_range(1, 3));
        end
        wait_drained();

        while (sent < RANDOM_WORDS) begin
            if (!hold_done && sent >= 100) begin
                hold_done    = 1'b1;
                hold_request = 1'b1;
                burst        = 40;
            end else begin
                burst = $urandom_range(1, 24);
            end
            for (int i = 0; i < burst; i++) begin
                offer_word(random_axis(), random_axis());
            end
            sent += burst;

            if (!pause_done && sent >= RANDOM_WORDS / 2) begin
                pause_done = 1'b1;
                wait_drained();
            end

            // Some bursts run straight into the next one, so stretches with
            // no gap on the input side occur as well.
            case ($urandom_range(0, 9))
                0, 1, 2: ;
                3, 4, 5, 6: go_quiet($urandom_range(1, 3));
                default: go_quiet($urandom_range(5, 15));
            endcase
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (ledger.outstanding() != 0) begin
            $error("%0d polar words never came out", ledger.outstanding());
            ledger.mismatches++;
        end
        if (ledger.mismatches == 0) begin
            $display("stick_polar_convert_core regression: pass");
        end else begin
            $display("stick_polar_convert_core regression: fail");
        end
        $finish;
    end

    // Safety net against a hung handshake: far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("stick_polar_convert_core regression: fail");
        $finish;
    end

endmodule

// File: stick_polar_convert_core.f
design/spc_pkg.sv
design/spc_axis_if.sv
design/spc_polar_if.sv
design/spc_prep.sv
design/spc_atan_step.sv
design/spc_root_step.sv
design/spc_angle_fix.sv
design/stick_polar_convert_core.sv
test/tb.sv
